// ===== design/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

	localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [20:0] MIN_2BYTE   = 21'h000080;
	localparam logic [20:0] MIN_3BYTE   = 21'h000800;

	// continuation counts of a pending sequence
	localparam logic [1:0] LEN_2BYTE = 2'd1;
	localparam logic [1:0] LEN_3BYTE = 2'd2;
	localparam logic [1:0] LEN_4BYTE = 2'd3;

	// Work for one input byte: n_flush replacement units, then n_tail units
	// taken from tail0 and tail1.
	typedef struct packed {
		logic [15:0] tail1;
		logic [15:0] tail0;
		logic [1:0]  n_tail;
		logic [2:0]  n_flush;
		logic        text_end;
	} u8u16_desc_t;

endpackage

`default_nettype wire

// ===== design/u8u16_front.sv =====
`default_nettype none

module u8u16_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [7:0]             data_byte,
	input  wire                    text_last,
	input  wire                    q_full,
	output logic                   q_push,
	output u8u16_pkg::u8u16_desc_t q_desc
);
	import u8u16_pkg::*;

	logic [20:0] code_accum_q;
	logic [1:0]  bytes_needed_q;
	logic [1:0]  bytes_seen_q;
	logic [1:0]  seq_length_q;

	logic [20:0] accum_d;
	logic [1:0]  needed_d;
	logic [1:0]  seen_d;
	logic [1:0]  length_d;

	logic        accept;
	logic        pending;
	logic        is_cont;
	logic [20:0] acc_next;
	logic [1:0]  seen_inc;
	logic [1:0]  need_dec;
	logic        bad_cp;
	logic [20:0] supp_off;
	logic [2:0]  total;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pending  = bytes_needed_q != 2'd0;
	assign is_cont  = data_byte[7:6] == 2'b10;
	assign acc_next = {code_accum_q[14:0], data_byte[5:0]};
	assign seen_inc = bytes_seen_q + 2'd1;
	assign need_dec = bytes_needed_q - 2'd1;
	assign supp_off = acc_next - SUPP_BASE;

	always_comb begin
		case (seq_length_q)
			LEN_2BYTE: bad_cp = acc_next < MIN_2BYTE;
			LEN_3BYTE: bad_cp = acc_next < MIN_3BYTE;
			default:   bad_cp = (acc_next < SUPP_BASE) || (acc_next > CP_MAX);
		endcase
	end

	always_comb begin
		q_desc          = '0;
		q_desc.text_end = text_last;
		accum_d         = code_accum_q;
		needed_d        = bytes_needed_q;
		seen_d          = bytes_seen_q;
		length_d        = seq_length_q;

		if (pending && is_cont) begin
			if (need_dec == 2'd0) begin
				// sequence complete
				accum_d  = '0;
				needed_d = '0;
				seen_d   = '0;
				length_d = '0;
				if (bad_cp || acc_next <= 21'h00FFFF) begin
					q_desc.tail0  = bad_cp ? REPL_UNIT : acc_next[15:0];
					q_desc.n_tail = 2'd1;
				end else begin
					q_desc.tail0  = HI_SURR | {6'd0, supp_off[19:10]};
					q_desc.tail1  = LO_SURR | {6'd0, supp_off[9:0]};
					q_desc.n_tail = 2'd2;
				end
			end else if (text_last) begin
				q_desc.n_flush = {1'b0, seen_inc} + 3'd1;
				accum_d  = '0;
				needed_d = '0;
				seen_d   = '0;
				length_d = '0;
			end else begin
				accum_d  = acc_next;
				needed_d = need_dec;
				seen_d   = seen_inc;
			end
		end else begin
			// cut short by a non-continuation byte: lead plus buffered bytes
			if (pending) begin
				q_desc.n_flush = {1'b0, bytes_seen_q} + 3'd1;
			end
			accum_d  = '0;
			needed_d = '0;
			seen_d   = '0;
			length_d = '0;
			if (data_byte[7] == 1'b0) begin
				q_desc.tail0  = {8'd0, data_byte};
				q_desc.n_tail = 2'd1;
			end else if (data_byte inside {[8'hC0:8'hF7]}) begin
				if (text_last) begin
					q_desc.n_flush = q_desc.n_flush + 3'd1;
				end else if (data_byte[5] == 1'b0) begin
					accum_d  = {16'd0, data_byte[4:0]};
					needed_d = LEN_2BYTE;
					length_d = LEN_2BYTE;
				end else if (data_byte[4] == 1'b0) begin
					accum_d  = {17'd0, data_byte[3:0]};
					needed_d = LEN_3BYTE;
					length_d = LEN_3BYTE;
				end else begin
					accum_d  = {18'd0, data_byte[2:0]};
					needed_d = LEN_4BYTE;
					length_d = LEN_4BYTE;
				end
			end else begin
				// stray continuation or invalid lead
				q_desc.tail0  = REPL_UNIT;
				q_desc.n_tail = 2'd1;
			end
		end
	end

	assign total  = q_desc.n_flush + {1'b0, q_desc.n_tail};
	assign q_push = accept && (total != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_accum_q   <= '0;
			bytes_needed_q <= '0;
			bytes_seen_q   <= '0;
			seq_length_q   <= '0;
		end else if (accept) begin
			code_accum_q   <= accum_d;
			bytes_needed_q <= needed_d;
			bytes_seen_q   <= seen_d;
			seq_length_q   <= length_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/u8u16_fifo.sv =====
`default_nettype none

module u8u16_fifo #(
	parameter int DEPTH = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  u8u16_pkg::u8u16_desc_t din,
	output logic                   full,
	input  wire                    pop,
	output u8u16_pkg::u8u16_desc_t dout,
	output logic                   empty
);
	import u8u16_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u8u16_desc_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/u8u16_back.sv =====
`default_nettype none

module u8u16_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_empty,
	input  u8u16_pkg::u8u16_desc_t q_desc,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [15:0]            utf16_unit,
	output logic                   run_last,
	output logic                   text_end
);
	import u8u16_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       xfer;

	assign total     = q_desc.n_flush + {1'b0, q_desc.n_tail};
	assign out_valid = !q_empty;
	assign run_last  = idx_q == (total - 3'd1);
	assign text_end  = run_last && q_desc.text_end;
	assign xfer      = out_valid && out_ready;
	assign q_pop     = xfer && run_last;

	always_comb begin
		if (idx_q < q_desc.n_flush) begin
			utf16_unit = REPL_UNIT;
		end else if (idx_q == q_desc.n_flush) begin
			utf16_unit = q_desc.tail0;
		end else begin
			utf16_unit = q_desc.tail1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= run_last ? '0 : idx_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

// ===== design/utf8_to_utf16_decoder.sv =====
`default_nettype none

// UTF-8 to UTF-16 decoder. Takes one UTF-8 byte per transfer (tlast on the final
// byte of the text) and gives UTF-16 code units, one per transfer. Each byte
// yields zero to four units: supplementary code points come out as surrogate
// pairs, cut-short sequences and stray bytes as U+FFFD per byte, an overlong or
// out-of-range sequence as a single U+FFFD. A byte is taken every cycle while
// the FIFO_DEPTH-entry queue between decoder and output stage has room; the
// output stage sends one unit per cycle while the output is ready, and keeps
// a byte's entry in the queue until it has sent its last unit. Output tlast
// marks the last unit from a byte, tuser the last unit of the text.
module utf8_to_utf16_decoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire         s_axis_tlast,   // text_last
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] utf16_unit
	output logic        m_axis_tlast,   // run_last
	output logic [0:0]  m_axis_tuser    // [0] text_end
);
	import u8u16_pkg::*;

	u8u16_desc_t push_desc;
	u8u16_desc_t head_desc;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	logic        text_end;

	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.data_byte (s_axis_tdata),
		.text_last (s_axis_tlast),
		.q_full    (full),
		.q_push    (push),
		.q_desc    (push_desc)
	);

	u8u16_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_desc),
		.full   (full),
		.pop    (pop),
		.dout   (head_desc),
		.empty  (empty)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (empty),
		.q_desc     (head_desc),
		.q_pop      (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.utf16_unit (m_axis_tdata),
		.run_last   (m_axis_tlast),
		.text_end   (text_end)
	);

	assign m_axis_tuser = text_end;

endmodule

`default_nettype wire

// ===== design/u8u16_checker.sv =====
`default_nettype none

module u8u16_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire [7:0]  s_axis_tdata,
	input wire        s_axis_tlast,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata,
	input wire        m_axis_tlast,
	input wire [0:0]  m_axis_tuser
);

	// end of text only on the last unit of a byte
	a_text_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("text end flagged on a unit that is not last of its byte");

	// an ASCII unit only comes from a lone ASCII byte, never mid-run
	a_ascii_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[15:7] == 9'd0) |-> m_axis_tlast)
		else $error("ASCII unit not at the end of its run");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
			$stable(m_axis_tuser))
		else $error("output changed while stalled");

	// input only stalls while the queue holds work for the output
	a_ready_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with nothing to send");

	// an ASCII byte or the end of text always produces a unit
	a_last_gives_unit: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tlast || !s_axis_tdata[7]) |=>
			m_axis_tvalid)
		else $error("no unit after an ASCII or end-of-text transfer");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_chk (.*);

`default_nettype wire
